>>> design/buddy_allocator_tree_assert.svh
// assertion macros shared by the checker
`ifndef BUDDY_ALLOCATOR_TREE_ASSERT_SVH
`define BUDDY_ALLOCATOR_TREE_ASSERT_SVH

// same-cycle implication, sampled on clk and disabled in reset
`define BAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// next-cycle implication
`define BAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

>>> design/bat_pkg.sv
package bat_pkg;

  localparam int POOL_LOG2_DEF = 10;
  localparam int BASE_W        = 48;
  localparam int SIZE_W        = 32;
  localparam int ALIGN_W       = 11;
  localparam int OFF_IN_W      = 32;
  localparam int OFF_OUT_W     = 10;
  localparam int BYTES_W       = 11;
  localparam int ERR_W         = 3;
  localparam int DIVIDEND_W    = BASE_W + 1;
  localparam int ST_W          = 2;
  // wide enough for a 33-bit padded size and a pool of up to 2^32
  localparam int CALC_W        = 34;

  typedef enum logic [ST_W-1:0] {
    ST_UNUSED  = 2'd0,
    ST_SPLIT   = 2'd1,
    ST_USED    = 2'd2,
    ST_USED_AL = 2'd3
  } node_st_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK            = 3'd0,
    ERR_TOO_LARGE     = 3'd1,
    ERR_NO_SPACE      = 3'd2,
    ERR_UNALLOCATED   = 3'd3,
    ERR_OUTSIDE       = 3'd4,
    ERR_NOT_START     = 3'd5,
    ERR_ALIGNED_START = 3'd6
  } err_t;

endpackage

>>> design/bat_req_if.sv
interface bat_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [bat_pkg::SIZE_W-1:0]    request_size;
  logic [bat_pkg::ALIGN_W-1:0]   alignment;
  logic [bat_pkg::OFF_IN_W-1:0]  free_offset;

  modport source (output valid, operation, request_size, alignment, free_offset,
                  input ready);
  modport sink (input valid, operation, request_size, alignment, free_offset,
                output ready);
endinterface

>>> design/bat_rsp_if.sv
interface bat_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [bat_pkg::OFF_OUT_W-1:0] block_offset;
  logic [bat_pkg::ERR_W-1:0]     error_code;
  logic [bat_pkg::BYTES_W-1:0]   bytes_in_use;

  modport source (output valid, success, block_offset, error_code, bytes_in_use,
                  input ready);
  modport sink (input valid, success, block_offset, error_code, bytes_in_use,
                output ready);
endinterface

>>> design/bat_ram.sv
module bat_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/bat_rem_unit.sv
module bat_rem_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bat_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [bat_pkg::ALIGN_W-1:0]      divisor,
  output logic                             done,
  output logic [bat_pkg::ALIGN_W-1:0]      rem
);

  localparam int CW = $clog2(bat_pkg::DIVIDEND_W);

  logic [CW-1:0]                     cnt_r;
  logic                              busy_r;
  logic                              done_r;
  logic [bat_pkg::DIVIDEND_W-1:0]    sh_r;
  logic [bat_pkg::ALIGN_W-1:0]       div_r;
  logic [bat_pkg::ALIGN_W-1:0]       r_r;
  logic [bat_pkg::ALIGN_W:0]         trial;
  logic [bat_pkg::ALIGN_W:0]         diff;
  logic [bat_pkg::ALIGN_W-1:0]       r_nxt;

  // restoring remainder, one dividend bit per cycle
  assign trial = {r_r, sh_r[bat_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign r_nxt = (trial >= {1'b0, div_r}) ? diff[bat_pkg::ALIGN_W-1:0]
                                          : trial[bat_pkg::ALIGN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(bat_pkg::DIVIDEND_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sh_r   <= dividend;
        div_r  <= divisor;
        r_r    <= '0;
      end else if (busy_r) begin
        r_r  <= r_nxt;
        sh_r <= sh_r << 1;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(bat_pkg::DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

>>> design/buddy_allocator_tree.sv
// Buddy allocator over a pool of 2^POOL_LOG2 bytes. Node states live in one
// single-port RAM (2 bits per node, heap order) with a registered read;
// a request is taken only when the block is idle and yields one result.
// After reset the block marks the root unused in S_INIT, then accepts
// requests. Each request is accepted in S_IDLE and its result is posted in
// S_DONE; posting waits while the previous result has not been taken.
// Requests rejected up front (too large, outside the pool) go straight to
// S_DONE. A free reads tree nodes on the way down, checks buddies on the way
// up (no buddy check once the root is reached), clears the merged node and
// marks each ancestor above it split. An allocate halves the pool to size the
// request, then reads the nodes it visits, writes both children of each node
// it splits, climbs levels on backtrack and, when alignment is above one,
// computes the bit-serial remainder of (base_address + offset) by the
// alignment. The user must write base_address through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
module buddy_allocator_tree #(
  parameter int POOL_LOG2 = bat_pkg::POOL_LOG2_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bat_pkg::BASE_W-1:0]  cfg_wr_data,
  bat_req_if.sink                     in_chan,
  bat_rsp_if.source                   out_chan
);

  localparam int IW    = POOL_LOG2 + 1;
  localparam int UW    = POOL_LOG2 + 1;
  localparam int LW    = $clog2(POOL_LOG2 + 2);
  localparam int NODES = (2 ** (POOL_LOG2 + 1)) - 1;
  localparam int AW    = $clog2(NODES);
  localparam int CW    = bat_pkg::CALC_W;
  localparam logic [CW-1:0] POOL = CW'(1) << POOL_LOG2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SIZE, S_RD, S_EV, S_SPL, S_SPR, S_CLIMB,
    S_RSTART, S_REM, S_MCHK, S_MEV, S_MWR, S_MUP, S_DONE
  } state_t;

  state_t                           state_r;
  logic [IW-1:0]                    idx_r;
  logic [LW-1:0]                    lvl_r;
  logic [LW-1:0]                    tl_r;
  logic [CW-1:0]                    plen_r;
  logic [CW-1:0]                    s_r;
  logic [bat_pkg::ALIGN_W-1:0]      align_r;
  logic                             op_r;
  logic [POOL_LOG2-1:0]             off_r;
  logic [UW-1:0]                    used_r;
  logic [POOL_LOG2-1:0]             noff_r;
  logic [bat_pkg::OFF_OUT_W-1:0]    boff_r;
  bat_pkg::err_t                    err_r;
  logic [bat_pkg::BASE_W-1:0]       base_r;

  logic                             out_valid_r;
  logic                             out_success_r;
  logic [bat_pkg::OFF_OUT_W-1:0]    out_boff_r;
  logic [bat_pkg::ERR_W-1:0]        out_err_r;
  logic [bat_pkg::BYTES_W-1:0]      out_bytes_r;

  logic                             ram_we;
  logic [AW-1:0]                    ram_addr;
  bat_pkg::node_st_t                ram_wd;
  logic [bat_pkg::ST_W-1:0]         ram_rdata;
  bat_pkg::node_st_t                st;

  logic                             rem_start;
  logic                             rem_done;
  logic [bat_pkg::ALIGN_W-1:0]      rem;
  logic [bat_pkg::DIVIDEND_W-1:0]   dividend;

  logic [IW-1:0]                    idx_l;
  logic [IW-1:0]                    par;
  logic [IW-1:0]                    sib;
  logic [LW-1:0]                    sh;
  logic [UW-1:0]                    blk;
  logic [IW-1:0]                    node_off_full;
  logic [CW-1:0]                    noff_ext;
  logic [UW-1:0]                    off_ext;
  logic [UW-1:0]                    off_dsh;
  logic                             is_start;
  logic                             obit;
  logic [bat_pkg::SIZE_W-1:0]       sz;
  logic [CW-1:0]                    s_calc;
  logic [CW-1:0]                    aligned;
  logic [CW-1:0]                    half;
  logic [UW+bat_pkg::BYTES_W-1:0]   used_ext;
  logic                             hit;
  logic                             desc;

  assign st       = bat_pkg::node_st_t'(ram_rdata);
  assign idx_l    = (idx_r << 1) + IW'(1);
  assign par      = (idx_r - IW'(1)) >> 1;
  assign sib      = idx_r[0] ? idx_r + IW'(1) : idx_r - IW'(1);
  assign sh       = LW'(POOL_LOG2) - lvl_r;
  assign blk      = UW'(1) << sh;
  assign node_off_full = ((idx_r + IW'(1)) - (IW'(1) << lvl_r)) << sh;
  assign noff_ext = CW'(node_off_full[POOL_LOG2-1:0]);
  assign off_ext  = {1'b0, off_r};
  assign is_start = (off_ext & (blk - UW'(1))) == '0;
  assign off_dsh  = off_ext >> (sh - LW'(1));
  assign obit     = off_dsh[0];
  assign sz       = (in_chan.request_size == '0) ? bat_pkg::SIZE_W'(1)
                                                 : in_chan.request_size;
  assign s_calc   = CW'(sz) + ((in_chan.alignment > bat_pkg::ALIGN_W'(1))
                    ? CW'(in_chan.alignment) - CW'(1) : '0);
  assign aligned  = CW'(noff_r) + CW'(align_r) - CW'(rem);
  assign half     = plen_r >> 1;
  assign used_ext = {{bat_pkg::BYTES_W{1'b0}}, used_r};
  assign hit      = (lvl_r == tl_r) && (st == bat_pkg::ST_UNUSED);
  assign desc     = (lvl_r != tl_r) &&
                    ((st == bat_pkg::ST_UNUSED) || (st == bat_pkg::ST_SPLIT));

  assign rem_start = (state_r == S_RSTART);
  assign dividend  = bat_pkg::DIVIDEND_W'(base_r) + bat_pkg::DIVIDEND_W'(noff_r);

  // ram port steering
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(idx_r);
    ram_wd   = bat_pkg::ST_UNUSED;
    case (state_r)
      S_INIT: begin
        ram_we   = 1'b1;
        ram_addr = '0;
      end
      S_EV: begin
        if (!op_r) begin
          if (hit && align_r <= bat_pkg::ALIGN_W'(1)) begin
            ram_we = 1'b1;
            ram_wd = bat_pkg::ST_USED;
          end else if (desc && st == bat_pkg::ST_UNUSED) begin
            ram_we = 1'b1;
            ram_wd = bat_pkg::ST_SPLIT;
          end
        end
      end
      S_SPL: begin
        ram_we   = 1'b1;
        ram_addr = AW'(idx_l);
      end
      S_SPR: begin
        ram_we   = 1'b1;
        ram_addr = AW'(idx_l + IW'(1));
      end
      S_REM: begin
        ram_we = rem_done;
        ram_wd = (rem != '0) ? bat_pkg::ST_USED_AL : bat_pkg::ST_USED;
      end
      S_MCHK: ram_addr = AW'(sib);
      S_MWR:  ram_we = 1'b1;
      S_MUP: begin
        ram_we   = 1'b1;
        ram_addr = AW'(par);
        ram_wd   = bat_pkg::ST_SPLIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      used_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: state_r <= S_IDLE;
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r    <= in_chan.operation;
            align_r <= in_chan.alignment;
            s_r     <= s_calc;
            off_r   <= in_chan.free_offset[POOL_LOG2-1:0];
            plen_r  <= POOL;
            idx_r   <= '0;
            lvl_r   <= '0;
            tl_r    <= '0;
            boff_r  <= '0;
            if (in_chan.operation) begin
              if (CW'(in_chan.free_offset) >= POOL) begin
                err_r   <= bat_pkg::ERR_OUTSIDE;
                state_r <= S_DONE;
              end else begin
                err_r   <= bat_pkg::ERR_OK;
                state_r <= S_RD;
              end
            end else if (s_calc > POOL) begin
              err_r   <= bat_pkg::ERR_TOO_LARGE;
              state_r <= S_DONE;
            end else begin
              err_r   <= bat_pkg::ERR_OK;
              state_r <= S_SIZE;
            end
          end
        end
        S_SIZE: begin
          // halve the block until the next half would be too small
          if (half >= s_r) begin
            plen_r <= half;
            tl_r   <= tl_r + LW'(1);
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          if (!op_r) begin
            if (hit) begin
              used_r <= used_r + UW'(plen_r);
              noff_r <= node_off_full[POOL_LOG2-1:0];
              if (align_r > bat_pkg::ALIGN_W'(1)) begin
                state_r <= S_RSTART;
              end else begin
                boff_r  <= noff_ext[bat_pkg::OFF_OUT_W-1:0];
                state_r <= S_DONE;
              end
            end else if (desc) begin
              if (st == bat_pkg::ST_UNUSED) begin
                state_r <= S_SPL;
              end else begin
                idx_r   <= idx_l;
                lvl_r   <= lvl_r + LW'(1);
                state_r <= S_RD;
              end
            end else if (idx_r[0]) begin
              idx_r   <= idx_r + IW'(1);
              state_r <= S_RD;
            end else if (idx_r == '0) begin
              err_r   <= bat_pkg::ERR_NO_SPACE;
              state_r <= S_DONE;
            end else begin
              state_r <= S_CLIMB;
            end
          end else begin
            if (st == bat_pkg::ST_USED || st == bat_pkg::ST_USED_AL) begin
              if (st == bat_pkg::ST_USED_AL && is_start) begin
                err_r   <= bat_pkg::ERR_ALIGNED_START;
                state_r <= S_DONE;
              end else if (st == bat_pkg::ST_USED && !is_start) begin
                err_r   <= bat_pkg::ERR_NOT_START;
                state_r <= S_DONE;
              end else begin
                used_r  <= used_r - blk;
                state_r <= S_MCHK;
              end
            end else if (st == bat_pkg::ST_UNUSED || lvl_r == LW'(POOL_LOG2)) begin
              err_r   <= bat_pkg::ERR_UNALLOCATED;
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_l + IW'(obit);
              lvl_r   <= lvl_r + LW'(1);
              state_r <= S_RD;
            end
          end
        end
        S_SPL: state_r <= S_SPR;
        S_SPR: begin
          idx_r   <= idx_l;
          lvl_r   <= lvl_r + LW'(1);
          state_r <= S_RD;
        end
        S_CLIMB: begin
          lvl_r <= lvl_r - LW'(1);
          if (par[0]) begin
            idx_r   <= par + IW'(1);
            state_r <= S_RD;
          end else if (par == '0) begin
            err_r   <= bat_pkg::ERR_NO_SPACE;
            state_r <= S_DONE;
          end else begin
            idx_r <= par;
          end
        end
        S_RSTART: state_r <= S_REM;
        S_REM: begin
          if (rem_done) begin
            boff_r  <= (rem != '0) ? aligned[bat_pkg::OFF_OUT_W-1:0]
                                   : noff_ext[bat_pkg::OFF_OUT_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_MCHK: state_r <= (idx_r == '0) ? S_MWR : S_MEV;
        S_MEV: begin
          if (st != bat_pkg::ST_UNUSED) begin
            state_r <= S_MWR;
          end else begin
            idx_r   <= par;
            state_r <= S_MCHK;
          end
        end
        S_MWR: state_r <= (idx_r == '0) ? S_DONE : S_MUP;
        S_MUP: begin
          idx_r <= par;
          if (par == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r   <= 1'b1;
            out_success_r <= (err_r == bat_pkg::ERR_OK);
            out_boff_r    <= (err_r == bat_pkg::ERR_OK) ? boff_r : '0;
            out_err_r     <= err_r;
            out_bytes_r   <= used_ext[bat_pkg::BYTES_W-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.success      = out_success_r;
  assign out_chan.block_offset = out_boff_r;
  assign out_chan.error_code   = out_err_r;
  assign out_chan.bytes_in_use = out_bytes_r;

  bat_ram #(
    .WIDTH (bat_pkg::ST_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rdata)
  );

  bat_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (dividend),
    .divisor  (align_r),
    .done     (rem_done),
    .rem      (rem)
  );

endmodule

>>> design/bat_checker.sv
`include "buddy_allocator_tree_assert.svh"

module bat_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          success,
  input logic [bat_pkg::OFF_OUT_W-1:0] block_offset,
  input logic [bat_pkg::ERR_W-1:0]     error_code
);

  // success flag and error code must agree
  `BAT_ASSERT_NOW(a_success_err, out_valid, success == (error_code == bat_pkg::ERR_OK))
  // a failed request never reports an offset
  `BAT_ASSERT_NOW(a_fail_zero_off, out_valid && !success, block_offset == '0)
  // one request in flight: ready drops right after a transaction
  `BAT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `BAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind buddy_allocator_tree bat_checker u_bat_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .success      (out_chan.success),
  .block_offset (out_chan.block_offset),
  .error_code   (out_chan.error_code)
);
